// ----- hdl/avne_pkg.sv -----
// Package with the word types, constants and helpers of the vertex normal estimator.
package avne_pkg;

   localparam int IDX_W           = 14;
   localparam int POS_W           = 24;
   localparam int EDGE_W          = 25;
   localparam int PROD_W          = 50;
   localparam int CROSS_W         = 51;
   localparam int NRM_W           = 56;
   localparam int SUM_W           = 57;
   localparam int CFG_W           = 16;
   localparam int DEF_MAX_VERTICES = 16384;
   localparam int MID_DEPTH       = 2;
   localparam int OUT_DEPTH       = 2;

   typedef enum logic [1:0] {
      CMD_WRITE_VERTEX = 2'd0,
      CMD_TRIANGLE     = 2'd1,
      CMD_CLEAR        = 2'd2,
      CMD_READ_NORMAL  = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type                  cmd;
      logic [IDX_W-1:0]         vertex_index;
      logic signed [POS_W-1:0]  pos_x;
      logic signed [POS_W-1:0]  pos_y;
      logic signed [POS_W-1:0]  pos_z;
      logic [IDX_W-1:0]         corner_first;
      logic [IDX_W-1:0]         corner_second;
      logic [IDX_W-1:0]         corner_third;
   } req_type;

   typedef struct packed {
      logic signed [NRM_W-1:0]  normal_x;
      logic signed [NRM_W-1:0]  normal_y;
      logic signed [NRM_W-1:0]  normal_z;
      logic                     face_used;
      logic                     saturated;
   } rsp_type;

   // A classified command as it waits between the front and the back.
   typedef struct packed {
      req_type  req;
      logic     face_used;
   } op_type;

   typedef struct packed {
      logic signed [POS_W-1:0]  x;
      logic signed [POS_W-1:0]  y;
      logic signed [POS_W-1:0]  z;
   } vertex_type;

   typedef struct packed {
      logic signed [NRM_W-1:0]  x;
      logic signed [NRM_W-1:0]  y;
      logic signed [NRM_W-1:0]  z;
   } nrm_vec_type;

   typedef struct packed {
      logic [CFG_W-1:0]  wdata;
      logic              wen;
   } csr_type;

   typedef enum logic [3:0] {
      B_CLEAR,
      B_IDLE,
      B_VWR,
      B_NRD,
      B_NCAP,
      B_VRD,
      B_MUL,
      B_UPD,
      B_RESP
   } back_state_type;

   typedef struct packed {
      logic signed [NRM_W-1:0]  value;
      logic                     sat;
   } sat_type;

   // Adds a signed delta into a 56-bit accumulator, clamping to its range.
   function automatic sat_type sat_add(logic signed [NRM_W-1:0] acc,
                                       logic signed [SUM_W-1:0] delta);
      logic signed [SUM_W-1:0] sum;
      sat_type r;
      sum = SUM_W'(acc) + delta;
      if (sum[SUM_W-1] != sum[SUM_W-2]) begin
         r.sat   = 1'b1;
         r.value = sum[SUM_W-1] ? {1'b1, {(NRM_W-1){1'b0}}} : {1'b0, {(NRM_W-1){1'b1}}};
      end else begin
         r.sat   = 1'b0;
         r.value = sum[NRM_W-1:0];
      end
      return r;
   endfunction

endpackage

// ----- hdl/avne_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module avne_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                      clock,
   input  logic                      we,
   input  logic [$clog2(DEPTH)-1:0]  waddr,
   input  logic [WIDTH-1:0]          wdata,
   input  logic [$clog2(DEPTH)-1:0]  raddr,
   output logic [WIDTH-1:0]          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- hdl/avne_fifo.sv -----
// Small register FIFO used between the front, the back and the result port.
module avne_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [WIDTH-1:0]  wdata,
   output logic              full,
   input  logic              pop,
   output logic [WIDTH-1:0]  rdata,
   output logic              empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ----- hdl/avne_front.sv -----
// Front end: accepts words, keeps the face counter and classifies triangles.
module avne_front (
   input  logic               clock,
   input  logic               reset,
   input  avne_pkg::csr_type  csr,
   input  logic               req_push,
   input  avne_pkg::req_type  req_data,
   output logic               req_full,
   input  logic               mid_full,
   input  logic               clearing,
   output logic               mid_push,
   output avne_pkg::op_type   mid_data
);
   import avne_pkg::*;

   logic [CFG_W-1:0] face_count_ff, face_count_in;
   logic [CFG_W-1:0] faces_seen_ff, faces_seen_in;

   assign req_full = mid_full || clearing;
   assign mid_push = req_push && !req_full;

   always_comb begin
      mid_data.req       = req_data;
      mid_data.face_used = (req_data.cmd == CMD_TRIANGLE) &&
                           (faces_seen_ff < (face_count_ff >> 1));
      face_count_in = csr.wen ? csr.wdata : face_count_ff;
      faces_seen_in = faces_seen_ff;
      if (mid_push) begin
         unique case (req_data.cmd)
            CMD_TRIANGLE: begin
               if (faces_seen_ff != {CFG_W{1'b1}}) begin
                  faces_seen_in = faces_seen_ff + 1'b1;
               end
            end
            CMD_CLEAR:        faces_seen_in = '0;
            CMD_WRITE_VERTEX: faces_seen_in = faces_seen_ff;
            CMD_READ_NORMAL:  faces_seen_in = faces_seen_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         face_count_ff <= '0;
         faces_seen_ff <= '0;
      end else begin
         face_count_ff <= face_count_in;
         faces_seen_ff <= faces_seen_in;
      end
   end

endmodule

// ----- hdl/avne_back.sv -----
// Back end: vertex and normal stores, cross product and saturating updates.
module avne_back #(
   parameter int MAX_VERTICES = avne_pkg::DEF_MAX_VERTICES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               mid_empty,
   input  avne_pkg::op_type   mid_data,
   output logic               mid_pop,
   input  logic               out_full,
   output logic               out_push,
   output avne_pkg::rsp_type  out_data,
   output logic               clearing
);
   import avne_pkg::*;

   localparam int AW = $clog2(MAX_VERTICES);

   function automatic logic idx_ok(logic [IDX_W-1:0] i);
      return 32'(i) < 32'(MAX_VERTICES);
   endfunction

   back_state_type           state_ff, state_in;
   op_type                   op_ff, op_in;
   logic [2:0]               step_ff, step_in;
   logic                     phase_ff, phase_in;
   logic [AW-1:0]            clr_ff, clr_in;
   logic                     clr_resp_ff, clr_resp_in;
   logic                     vok_ff, vok_in;
   logic                     sat_ff, sat_in;
   vertex_type               p0_ff, p0_in;
   logic signed [EDGE_W-1:0] d1_ff [3];
   logic signed [EDGE_W-1:0] d1_in [3];
   logic signed [EDGE_W-1:0] d2_ff [3];
   logic signed [EDGE_W-1:0] d2_in [3];
   logic signed [CROSS_W-1:0] cr_ff [3];
   logic signed [CROSS_W-1:0] cr_in [3];
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   rsp_type                  res_ff, res_in;

   logic                     vtx_we;
   logic [AW-1:0]            vtx_waddr, vtx_raddr;
   vertex_type               vtx_wdata, vtx_rdata, pos;
   logic                     nrm_we;
   logic [AW-1:0]            nrm_waddr, nrm_raddr;
   nrm_vec_type              nrm_wdata, nrm_rdata;

   logic [IDX_W-1:0]         vrd_corner, upd_base, upd_idx;
   logic                     upd_sub;
   logic signed [EDGE_W-1:0] mul_a, mul_b;
   logic [2:0]               step_m1;
   sat_type                  sx, sy, sz;

   avne_ram #(.WIDTH($bits(vertex_type)), .DEPTH(MAX_VERTICES)) u_vertex_ram (
      .clock (clock),
      .we    (vtx_we),
      .waddr (vtx_waddr),
      .wdata (vtx_wdata),
      .raddr (vtx_raddr),
      .rdata (vtx_rdata)
   );

   avne_ram #(.WIDTH($bits(nrm_vec_type)), .DEPTH(MAX_VERTICES)) u_normal_ram (
      .clock (clock),
      .we    (nrm_we),
      .waddr (nrm_waddr),
      .wdata (nrm_wdata),
      .raddr (nrm_raddr),
      .rdata (nrm_rdata)
   );

   always_comb begin
      unique case (step_ff[1:0])
         2'd0:    vrd_corner = op_ff.req.corner_first;
         2'd1:    vrd_corner = op_ff.req.corner_second;
         default: vrd_corner = op_ff.req.corner_third;
      endcase
      upd_sub = (step_ff >= 3'd3);
      if (step_ff == 3'd0 || step_ff == 3'd3) begin
         upd_base = op_ff.req.corner_first;
      end else if (step_ff == 3'd1 || step_ff == 3'd4) begin
         upd_base = op_ff.req.corner_second;
      end else begin
         upd_base = op_ff.req.corner_third;
      end
      upd_idx = upd_base ^ IDX_W'(upd_sub);
      unique case (step_ff)
         3'd0:    begin mul_a = d1_ff[1]; mul_b = d2_ff[2]; end
         3'd1:    begin mul_a = d1_ff[2]; mul_b = d2_ff[1]; end
         3'd2:    begin mul_a = d1_ff[2]; mul_b = d2_ff[0]; end
         3'd3:    begin mul_a = d1_ff[0]; mul_b = d2_ff[2]; end
         3'd4:    begin mul_a = d1_ff[0]; mul_b = d2_ff[1]; end
         default: begin mul_a = d1_ff[1]; mul_b = d2_ff[0]; end
      endcase
      step_m1 = step_ff - 3'd1;
      pos = vok_ff ? vtx_rdata : '0;
      sx = sat_add(nrm_rdata.x, upd_sub ? -SUM_W'(cr_ff[0]) : SUM_W'(cr_ff[0]));
      sy = sat_add(nrm_rdata.y, upd_sub ? -SUM_W'(cr_ff[1]) : SUM_W'(cr_ff[1]));
      sz = sat_add(nrm_rdata.z, upd_sub ? -SUM_W'(cr_ff[2]) : SUM_W'(cr_ff[2]));
   end

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      step_in     = step_ff;
      phase_in    = phase_ff;
      clr_in      = clr_ff;
      clr_resp_in = clr_resp_ff;
      vok_in      = vok_ff;
      sat_in      = sat_ff;
      p0_in       = p0_ff;
      d1_in       = d1_ff;
      d2_in       = d2_ff;
      cr_in       = cr_ff;
      prod_in     = prod_ff;
      res_in      = res_ff;
      mid_pop     = 1'b0;
      out_push    = 1'b0;
      vtx_we      = 1'b0;
      vtx_waddr   = AW'(op_ff.req.vertex_index);
      vtx_wdata   = {op_ff.req.pos_x, op_ff.req.pos_y, op_ff.req.pos_z};
      vtx_raddr   = AW'(vrd_corner);
      nrm_we      = 1'b0;
      nrm_waddr   = AW'(upd_idx);
      nrm_wdata   = {sx.value, sy.value, sz.value};
      nrm_raddr   = (state_ff == B_UPD) ? AW'(upd_idx) : AW'(op_ff.req.vertex_index);

      unique case (state_ff)
         B_CLEAR: begin
            nrm_we    = 1'b1;
            nrm_waddr = clr_ff;
            nrm_wdata = '0;
            if (32'(clr_ff) == 32'(MAX_VERTICES - 1)) begin
               clr_in   = '0;
               state_in = clr_resp_ff ? B_RESP : B_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         B_IDLE: begin
            if (!mid_empty) begin
               mid_pop          = 1'b1;
               op_in            = mid_data;
               step_in          = '0;
               phase_in         = 1'b0;
               sat_in           = 1'b0;
               res_in           = '0;
               res_in.face_used = mid_data.face_used;
               unique case (mid_data.req.cmd)
                  CMD_WRITE_VERTEX: state_in = B_VWR;
                  CMD_TRIANGLE:     state_in = mid_data.face_used ? B_VRD : B_RESP;
                  CMD_CLEAR: begin
                     clr_resp_in = 1'b1;
                     clr_in      = '0;
                     state_in    = B_CLEAR;
                  end
                  CMD_READ_NORMAL:  state_in = B_NRD;
               endcase
            end
         end
         B_VWR: begin
            vtx_we   = idx_ok(op_ff.req.vertex_index);
            state_in = B_RESP;
         end
         B_NRD: begin
            vok_in   = idx_ok(op_ff.req.vertex_index);
            state_in = B_NCAP;
         end
         B_NCAP: begin
            if (vok_ff) begin
               res_in.normal_x = nrm_rdata.x;
               res_in.normal_y = nrm_rdata.y;
               res_in.normal_z = nrm_rdata.z;
            end
            state_in = B_RESP;
         end
         B_VRD: begin
            // Corner reads are issued one per step; each answer lands a step later.
            vok_in  = idx_ok(vrd_corner);
            step_in = step_ff + 3'd1;
            unique case (step_ff)
               3'd1: p0_in = pos;
               3'd2: begin
                  d1_in[0] = EDGE_W'(pos.x) - EDGE_W'(p0_ff.x);
                  d1_in[1] = EDGE_W'(pos.y) - EDGE_W'(p0_ff.y);
                  d1_in[2] = EDGE_W'(pos.z) - EDGE_W'(p0_ff.z);
               end
               3'd3: begin
                  d2_in[0] = EDGE_W'(pos.x) - EDGE_W'(p0_ff.x);
                  d2_in[1] = EDGE_W'(pos.y) - EDGE_W'(p0_ff.y);
                  d2_in[2] = EDGE_W'(pos.z) - EDGE_W'(p0_ff.z);
                  step_in  = '0;
                  state_in = B_MUL;
               end
               default: p0_in = p0_ff;
            endcase
         end
         B_MUL: begin
            // One multiplier, six products; each is folded into the cross product
            // the step after it is formed.
            step_in = step_ff + 3'd1;
            if (step_ff != 3'd6) begin
               prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
            end
            if (step_ff != 3'd0) begin
               unique case (step_m1)
                  3'd0:    cr_in[0] = CROSS_W'(prod_ff);
                  3'd1:    cr_in[0] = cr_ff[0] - CROSS_W'(prod_ff);
                  3'd2:    cr_in[1] = CROSS_W'(prod_ff);
                  3'd3:    cr_in[1] = cr_ff[1] - CROSS_W'(prod_ff);
                  3'd4:    cr_in[2] = CROSS_W'(prod_ff);
                  default: cr_in[2] = cr_ff[2] - CROSS_W'(prod_ff);
               endcase
            end
            if (step_ff == 3'd6) begin
               step_in  = '0;
               phase_in = 1'b0;
               state_in = B_UPD;
            end
         end
         B_UPD: begin
            if (!phase_ff && idx_ok(upd_idx)) begin
               phase_in = 1'b1;
            end else begin
               if (phase_ff) begin
                  nrm_we   = 1'b1;
                  sat_in   = sat_ff || sx.sat || sy.sat || sz.sat;
                  phase_in = 1'b0;
               end
               if (step_ff == 3'd5) begin
                  state_in = B_RESP;
               end else begin
                  step_in = step_ff + 3'd1;
               end
            end
         end
         B_RESP: begin
            out_push = !out_full;
            if (!out_full) begin
               clr_resp_in = 1'b0;
               state_in    = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      out_data           = res_ff;
      out_data.saturated = sat_ff;
   end

   assign clearing = (state_ff == B_CLEAR);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= B_CLEAR;
         clr_ff      <= '0;
         clr_resp_ff <= 1'b0;
         step_ff     <= '0;
         phase_ff    <= 1'b0;
         sat_ff      <= 1'b0;
         vok_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         clr_resp_ff <= clr_resp_in;
         step_ff     <= step_in;
         phase_ff    <= phase_in;
         sat_ff      <= sat_in;
         vok_ff      <= vok_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      p0_ff   <= p0_in;
      d1_ff   <= d1_in;
      d2_ff   <= d2_in;
      cr_ff   <= cr_in;
      prod_ff <= prod_in;
      res_ff  <= res_in;
   end

   a_no_result_while_clearing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_CLEAR) |-> !out_push)
      else $error("result pushed during a clearing pass");

   a_normal_write_in_range: assert property (@(posedge clock) disable iff (reset)
      nrm_we |-> (32'(nrm_waddr) < 32'(MAX_VERTICES)))
      else $error("normal store written beyond its depth");

   a_face_used_only_triangle: assert property (@(posedge clock) disable iff (reset)
      (out_push && out_data.face_used) |-> (op_ff.req.cmd == CMD_TRIANGLE))
      else $error("face_used set on a non-triangle result");

   a_pop_starts_work: assert property (@(posedge clock) disable iff (reset)
      mid_pop |=> (state_ff != B_IDLE))
      else $error("command popped but back end stayed idle");

endmodule

// ----- hdl/antipodal_vertex_normal_estimator.sv -----
// Top level of the antipodal vertex normal estimator.
//
// Commands enter on the req_ queue port: a word is taken on a clock edge with
// req_push high and req_full low. Each word produces exactly one result word on
// the rsp_ port, in order; a result is offered while rsp_empty is low and is
// taken on an edge with rsp_pop high. The csr_ port writes face_count.
// An accumulated triangle makes six updates of the normal store, three corners
// and three partners; each in-range update is a read followed by a write.
// The back end takes the next word the cycle after it hands off a result.
// A clear command sweeps the normal memory one entry per cycle before its result
// is offered. Items are worked one at a time in the back end while the front
// queue keeps taking words.
// After reset the block runs the same clearing pass and holds req_full high
// until it ends. If the receiver stalls, results collect in a two-entry output
// queue, then the back end waits and the input queue fills until req_full
// rises; nothing is dropped.
module antipodal_vertex_normal_estimator #(
   parameter int MAX_VERTICES = avne_pkg::DEF_MAX_VERTICES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  avne_pkg::req_type             req_data,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output avne_pkg::rsp_type             rsp_data,
   input  logic                          csr_wr_en,
   input  logic [avne_pkg::CFG_W-1:0]    csr_wr_data
);
   import avne_pkg::*;

   csr_type  csr;
   logic     mid_push, mid_full, mid_pop, mid_empty;
   op_type   mid_wdata, mid_rdata;
   logic     out_push, out_full;
   rsp_type  out_wdata;
   logic     clearing;

   assign csr.wen   = csr_wr_en;
   assign csr.wdata = csr_wr_data;

   // The front classifies each word and tracks the running face number.
   avne_front u_front (
      .clock    (clock),
      .reset    (reset),
      .csr      (csr),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .mid_full (mid_full),
      .clearing (clearing),
      .mid_push (mid_push),
      .mid_data (mid_wdata)
   );

   // The short queue lets the front keep taking words while the back works.
   avne_fifo #(.WIDTH($bits(op_type)), .DEPTH(MID_DEPTH)) u_mid_fifo (
      .clock (clock),
      .reset (reset),
      .push  (mid_push),
      .wdata (mid_wdata),
      .full  (mid_full),
      .pop   (mid_pop),
      .rdata (mid_rdata),
      .empty (mid_empty)
   );

   avne_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_data  (mid_rdata),
      .mid_pop   (mid_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_data  (out_wdata),
      .clearing  (clearing)
   );

   // The output queue parts the back end from a stalling receiver.
   avne_fifo #(.WIDTH($bits(rsp_type)), .DEPTH(OUT_DEPTH)) u_out_fifo (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_wdata),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (rsp_data),
      .empty (rsp_empty)
   );

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the antipodal vertex normal estimator.
`timescale 1ns / 1ps

module tb;
   import avne_pkg::*;

   localparam int  NVERT      = DEF_MAX_VERTICES;
   localparam int  CYCLE_CAP  = 4000000;
   localparam int  SETTLE     = 40;
   localparam longint NRM_MAX = 64'sd36028797018963967;
   localparam longint NRM_MIN = -NRM_MAX - 1;
   localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
   localparam logic signed [POS_W-1:0] POS_MIN = 24'sh800000;

   // The predictor keeps its own copy of the vertex and normal stores, the face
   // counter and the face_count register, and queues one expected word per command.
   class normal_tracker;
      longint   vpos [NVERT][3];
      longint   nacc [NVERT][3];
      int       faces_seen;
      int       face_count;
      rsp_type  expected_words[$];
      int       errors;

      function new();
         foreach (vpos[i, k]) begin
            vpos[i][k] = 0;
            nacc[i][k] = 0;
         end
         faces_seen = 0;
         face_count = 0;
         errors     = 0;
      endfunction

      function void set_face_count(int value);
         face_count = value & 16'hFFFF;
      endfunction

      // Adds one signed delta into a 56-bit accumulator and clamps it.
      function bit sat_update(int idx, int k, longint delta);
         longint sum;
         sum = nacc[idx][k] + delta;
         if (sum > NRM_MAX) begin
            nacc[idx][k] = NRM_MAX;
            return 1'b1;
         end
         if (sum < NRM_MIN) begin
            nacc[idx][k] = NRM_MIN;
            return 1'b1;
         end
         nacc[idx][k] = sum;
         return 1'b0;
      endfunction

      function void accept_command(req_type w);
         rsp_type r;
         int      c [3];
         longint  d1 [3];
         longint  d2 [3];
         longint  cr [3];
         bit      sat;
         r   = '0;
         sat = 1'b0;
         case (w.cmd)
            CMD_WRITE_VERTEX: begin
               vpos[w.vertex_index][0] = longint'($signed(w.pos_x));
               vpos[w.vertex_index][1] = longint'($signed(w.pos_y));
               vpos[w.vertex_index][2] = longint'($signed(w.pos_z));
            end
            CMD_TRIANGLE: begin
               c[0] = int'(w.corner_first);
               c[1] = int'(w.corner_second);
               c[2] = int'(w.corner_third);
               if (faces_seen < (face_count >> 1)) begin
                  for (int k = 0; k < 3; k++) begin
                     d1[k] = vpos[c[1]][k] - vpos[c[0]][k];
                     d2[k] = vpos[c[2]][k] - vpos[c[0]][k];
                  end
                  cr[0] = d1[1] * d2[2] - d1[2] * d2[1];
                  cr[1] = d1[2] * d2[0] - d1[0] * d2[2];
                  cr[2] = d1[0] * d2[1] - d1[1] * d2[0];
                  for (int j = 0; j < 3; j++)
                     for (int k = 0; k < 3; k++)
                        sat |= sat_update(c[j], k, cr[k]);
                  for (int j = 0; j < 3; j++)
                     for (int k = 0; k < 3; k++)
                        sat |= sat_update(c[j] ^ 1, k, -cr[k]);
                  r.face_used = 1'b1;
                  r.saturated = sat;
               end
               if (faces_seen < 65535)
                  faces_seen++;
            end
            CMD_CLEAR: begin
               foreach (nacc[i, k])
                  nacc[i][k] = 0;
               faces_seen = 0;
            end
            default: begin
               r.normal_x = nacc[w.vertex_index][0][NRM_W-1:0];
               r.normal_y = nacc[w.vertex_index][1][NRM_W-1:0];
               r.normal_z = nacc[w.vertex_index][2][NRM_W-1:0];
            end
         endcase
         expected_words.push_back(r);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_words.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: unexpected result word %h", got);
            return;
         end
         want = expected_words.pop_front();
         if (got.normal_x !== want.normal_x || got.normal_y !== want.normal_y ||
             got.normal_z !== want.normal_z || got.face_used !== want.face_used ||
             got.saturated !== want.saturated) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: expected x=%h y=%h z=%h used=%b sat=%b, got x=%h y=%h z=%h used=%b sat=%b",
                        want.normal_x, want.normal_y, want.normal_z, want.face_used,
                        want.saturated, got.normal_x, got.normal_y, got.normal_z,
                        got.face_used, got.saturated);
         end
      endfunction
   endclass

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_push    = 1'b0;
   logic              req_full;
   req_type           req_data    = '0;
   logic              rsp_empty;
   logic              rsp_pop     = 1'b0;
   rsp_type           rsp_data;
   logic              csr_wr_en   = 1'b0;
   logic [CFG_W-1:0]  csr_wr_data = '0;

   normal_tracker tracker = new();
   int  cycle_count = 0;
   bit  tx_calm     = 1'b0;   // When set, the sender offers a word every cycle.
   bit  rx_calm     = 1'b0;   // When set, the receiver pops every cycle outside a long hold-off.
   bit  hold_req    = 1'b0;   // Asks the receiver for one long hold-off.
   bit  written [NVERT];
   int  written_pool[$];

   antipodal_vertex_normal_estimator u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The cap is far above the slowest correct run: one clearing pass after reset,
   // a sweep per clear command, and every word paying the longest stalls.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_CAP) begin
         $display("antipodal_vertex_normal_estimator: mismatch");
         $finish;
      end
   end

   // Gap lengths: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Offers one word until the block takes it, then notes it and may idle a while.
   task automatic send_word(req_type w);
      int gap;
      req_data <= w;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      tracker.accept_command(w);
      gap = tx_calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_vertex(int idx, logic signed [POS_W-1:0] x,
                               logic signed [POS_W-1:0] y, logic signed [POS_W-1:0] z);
      req_type w;
      w              = '0;
      w.cmd          = CMD_WRITE_VERTEX;
      w.vertex_index = IDX_W'(idx);
      w.pos_x        = x;
      w.pos_y        = y;
      w.pos_z        = z;
      w.corner_first = IDX_W'($urandom);
      send_word(w);
      if (!written[idx]) begin
         written[idx] = 1'b1;
         written_pool.push_back(idx);
      end
   endtask

   task automatic triangle(int a, int b, int c);
      req_type w;
      w               = '0;
      w.cmd           = CMD_TRIANGLE;
      w.vertex_index  = IDX_W'($urandom);
      w.pos_x         = POS_W'($urandom);
      w.corner_first  = IDX_W'(a);
      w.corner_second = IDX_W'(b);
      w.corner_third  = IDX_W'(c);
      send_word(w);
   endtask

   task automatic simple_cmd(cmd_type op, int idx);
      req_type w;
      w              = '0;
      w.cmd          = op;
      w.vertex_index = IDX_W'(idx);
      w.pos_y        = POS_W'($urandom);
      w.corner_third = IDX_W'($urandom);
      send_word(w);
   endtask

   // Waits until every expected word has come back, then lets the block settle
   // before the register may change.
   task automatic wait_idle();
      req_push <= 1'b0;
      while (tracker.expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_face_count(int value);
      csr_wr_data <= CFG_W'(value);
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      tracker.set_face_count(value);
   endtask

   function automatic logic signed [POS_W-1:0] random_pos();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return POS_MAX;
      if (r == 1) return POS_MIN;
      return POS_W'($urandom);
   endfunction

   function automatic int pool_pick();
      return written_pool[$urandom_range(0, written_pool.size() - 1)];
   endfunction

   // Receiver: pops with random stalls (none while rx_calm is set), and on request holds off for a long
   // stretch so the output and input queues fill and req_full rises.
   initial begin
      int wait_left;
      int hold_left;
      bit p;
      wait_left = 0;
      hold_left = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_left > 0) begin
            p = 1'b0;
            hold_left--;
         end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = 400;
            p         = 1'b0;
         end else if (rx_calm || wait_left == 0) begin
            p         = 1'b1;
            wait_left = rx_calm ? 0 : pick_gap();
         end else begin
            p = 1'b0;
            wait_left--;
         end
         rsp_pop <= p;
         @(posedge clock);
         if (p && rsp_empty === 1'b0)
            tracker.check_result(rsp_data);
      end
   end

   initial begin
      int settings [8];
      int base;
      int r;
      settings = '{65535, 0, 1, 2, 3, 32768, 4, 0};
      settings[7] = $urandom_range(0, 65535);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: extreme positions and indices, a degenerate triangle,
      // antipodal partners, a clear and reads of untouched normals.
      write_face_count(65535);
      write_vertex(0, 0, 0, 0);
      write_vertex(1, POS_MAX, 0, 0);
      write_vertex(2, 0, POS_MAX, 0);
      write_vertex(16383, POS_MIN, POS_MIN, POS_MIN);
      write_vertex(16382, POS_MAX, POS_MIN, POS_MAX);
      triangle(0, 1, 2);
      triangle(16383, 16382, 1);
      triangle(0, 0, 0);
      simple_cmd(CMD_READ_NORMAL, 0);
      simple_cmd(CMD_READ_NORMAL, 1);
      simple_cmd(CMD_READ_NORMAL, 3);
      simple_cmd(CMD_READ_NORMAL, 16383);
      simple_cmd(CMD_READ_NORMAL, 16382);
      simple_cmd(CMD_READ_NORMAL, 5);
      simple_cmd(CMD_CLEAR, 0);
      simple_cmd(CMD_READ_NORMAL, 1);
      triangle(2, 1, 0);
      simple_cmd(CMD_READ_NORMAL, 2);
      wait_idle();

      // Saturation run: one large triangle repeated so that the z sum of every corner
      // clamps high and that of every partner clamps low.
      base = 8 + 4 * $urandom_range(0, 4000);
      write_vertex(base, POS_MIN, 0, 0);
      write_vertex(base + 2, POS_MAX, POS_MIN, 0);
      write_vertex(base + 4, POS_MAX, POS_MAX, 0);
      hold_req = 1'b1;
      repeat (150) triangle(base, base + 2, base + 4);
      simple_cmd(CMD_READ_NORMAL, base);
      simple_cmd(CMD_READ_NORMAL, base + 1);
      wait_idle();

      // Random phases, each under its own face_count and idling mode.
      for (int ph = 0; ph < 8; ph++) begin
         write_face_count(settings[ph]);
         tx_calm = (ph % 3 == 1);
         rx_calm = (ph % 4 == 2);
         if (ph == 5) hold_req = 1'b1;
         simple_cmd(CMD_CLEAR, $urandom);
         for (int n = 0; n < 110; n++) begin
            r = $urandom_range(0, 999);
            if (r < 220 || written_pool.size() < 3)
               write_vertex(written_pool.size() > 40 && r < 80 ? pool_pick()
                            : $urandom_range(0, NVERT - 1),
                            random_pos(), random_pos(), random_pos());
            else if (r < 760)
               triangle(pool_pick(), pool_pick(), pool_pick());
            else if (r < 997)
               simple_cmd(CMD_READ_NORMAL, r < 900 ? pool_pick() ^ (r & 1)
                          : $urandom_range(0, NVERT - 1));
            else
               simple_cmd(CMD_CLEAR, $urandom);
         end
         wait_idle();
      end

      if (tracker.errors == 0 && tracker.expected_words.size() == 0)
         $display("antipodal_vertex_normal_estimator: match");
      else
         $display("antipodal_vertex_normal_estimator: mismatch");
      $finish;
   end

endmodule
